[src/usp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usp_pkg
// Types, character constants and classification helpers for the URI
// component splitter.
// ----------------------------------------------------------------------------
package usp_pkg;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SCHEME,
    PH_COLON,
    PH_AUTH,
    PH_PATH,
    PH_QUERY,
    PH_FRAG,
    PH_ENDED
  } phase_t;

  typedef enum logic [2:0] {
    PART_SCHEME,
    PART_AUTH,
    PART_PATH,
    PART_QUERY,
    PART_FRAG,
    PART_NONE
  } part_t;

  typedef struct packed {
    logic [7:0] out_byte;
    part_t      part;
    logic       out_last;
    logic       accepted;
  } result_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // result queue depth; must hold two new results behind one stalled one
  localparam int unsigned QDEPTH = 4;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_scheme_char(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) ||
           c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
  endfunction

  function automatic phase_t path_class(input logic [7:0] c);
    if (c == CH_QUEST) return PH_QUERY;
    if (c == CH_HASH) return PH_FRAG;
    return PH_PATH;
  endfunction

  // label for a byte taken in one of the post-scheme phases
  function automatic part_t phase_part(input phase_t ph);
    case (ph)
      PH_AUTH:  return PART_AUTH;
      PH_PATH:  return PART_PATH;
      PH_QUERY: return PART_QUERY;
      PH_FRAG:  return PART_FRAG;
      default:  return PART_NONE;
    endcase
  endfunction

  function automatic result_t mk_res(input logic [7:0] b, input part_t p);
    result_t r;
    r.out_byte = b;
    r.part     = p;
    r.out_last = 1'b0;
    r.accepted = 1'b0;
    return r;
  endfunction

endpackage

[src/usp_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usp_in_if
// Input byte channel: one URI character per item.
// ----------------------------------------------------------------------------
interface usp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

[src/usp_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usp_out_if
// Result channel: labelled character with component code and verdict.
// ----------------------------------------------------------------------------
interface usp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] part;
  logic       out_last;
  logic       accepted;

  modport source (output valid, output out_byte, output part, output out_last,
                  output accepted, input ready);
  modport sink (input valid, input out_byte, input part, input out_last,
                input accepted, output ready);
endinterface

[src/uri_component_splitter.sv]
`timescale 1ns / 1ps
// Results are registered in the result queue when their input item is accepted.
// Throughput: one input item per cycle while the queue has room; the output
//   side moves one result per cycle while dout.ready is high.
// A 4-entry result queue decouples the sides; input is taken while it has
//   room for two results.
// Reset (synchronous): phase machine to scheme start, queue emptied.
// ----------------------------------------------------------------------------
// uri_component_splitter
// Labels each URI byte with its component (scheme, authority, path, query,
// fragment) and gives an accept/reject verdict on the final result.
// ----------------------------------------------------------------------------
module uri_component_splitter (
  input  logic         clk,
  input  logic         rst,
  usp_in_if.sink       din,
  usp_out_if.source    dout
);
  import usp_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  phase_t  phase, phase_next;
  logic    slash_held, slash_held_next;
  logic    failed, failed_next;

  result_t r0, r1;
  logic [1:0] n_res;

  result_t         q [QDEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;
  logic            push, pop;

  // per-item labelling
  always_comb begin
    logic [7:0] b;
    b               = din.in_byte;
    phase_next      = phase;
    slash_held_next = slash_held;
    failed_next     = failed;
    r0              = mk_res(b, PART_NONE);
    r1              = mk_res(b, PART_NONE);
    n_res           = 2'd1;

    if (phase == PH_ENDED) begin
      r0 = mk_res(b, PART_NONE);
    end else if (b == CH_NUL) begin
      if (slash_held) begin
        r0    = mk_res(CH_SLASH, PART_PATH);
        r1    = mk_res(CH_NUL, PART_NONE);
        n_res = 2'd2;
      end else begin
        r0 = mk_res(CH_NUL, PART_NONE);
      end
      slash_held_next = 1'b0;
      if (phase == PH_FIRST || phase == PH_SCHEME) failed_next = 1'b1;
      phase_next = PH_ENDED;
    end else begin
      case (phase)
        PH_FIRST: begin
          if (is_alpha(b)) begin
            phase_next = PH_SCHEME;
            r0 = mk_res(b, PART_SCHEME);
          end else begin
            failed_next = 1'b1;
            phase_next  = PH_ENDED;
          end
        end
        PH_SCHEME: begin
          if (b == CH_COLON) begin
            phase_next = PH_COLON;
            r0 = mk_res(b, PART_SCHEME);
          end else if (is_scheme_char(b)) begin
            r0 = mk_res(b, PART_SCHEME);
          end else begin
            failed_next = 1'b1;
            phase_next  = PH_ENDED;
          end
        end
        PH_COLON: begin
          if (slash_held) begin
            slash_held_next = 1'b0;
            n_res = 2'd2;
            if (b == CH_SLASH) begin
              phase_next = PH_AUTH;
              r0 = mk_res(CH_SLASH, PART_AUTH);
              r1 = mk_res(b, PART_AUTH);
            end else begin
              phase_next = path_class(b);
              r0 = mk_res(CH_SLASH, PART_PATH);
              r1 = mk_res(b, phase_part(path_class(b)));
            end
          end else if (b == CH_SLASH) begin
            // wait for the next byte to tell "//" from a path
            slash_held_next = 1'b1;
            n_res = 2'd0;
          end else begin
            phase_next = path_class(b);
            r0 = mk_res(b, phase_part(path_class(b)));
          end
        end
        PH_AUTH: begin
          if (b == CH_SLASH) phase_next = PH_PATH;
          else if (b == CH_QUEST) phase_next = PH_QUERY;
          else if (b == CH_HASH) phase_next = PH_FRAG;
          r0 = mk_res(b, phase_part(phase_next));
        end
        PH_PATH: begin
          phase_next = path_class(b);
          r0 = mk_res(b, phase_part(path_class(b)));
        end
        PH_QUERY: begin
          if (b == CH_HASH) phase_next = PH_FRAG;
          r0 = mk_res(b, phase_part(phase_next));
        end
        default: begin
          r0 = mk_res(b, phase_part(phase));
        end
      endcase
    end

    if (din.in_last) begin
      if (slash_held_next) begin
        // held slash is only ever pending with no result yet from this item
        r0    = mk_res(CH_SLASH, PART_PATH);
        n_res = 2'd1;
      end
      if (n_res == 2'd1) begin
        r0.out_last = 1'b1;
        r0.accepted = !failed_next && phase_next != PH_FIRST &&
                      phase_next != PH_SCHEME;
      end else begin
        r1.out_last = 1'b1;
        r1.accepted = !failed_next && phase_next != PH_FIRST &&
                      phase_next != PH_SCHEME;
      end
      phase_next      = PH_FIRST;
      slash_held_next = 1'b0;
      failed_next     = 1'b0;
    end
  end

  assign din.ready = (count <= CW'(QDEPTH - 2));
  assign push      = din.valid && din.ready;
  assign pop       = dout.valid && dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      slash_held <= 1'b0;
      failed     <= 1'b0;
    end else if (push) begin
      phase      <= phase_next;
      slash_held <= slash_held_next;
      failed     <= failed_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (push && n_res != 2'd0) q[wptr] <= r0;
    if (push && n_res == 2'd2) q[wptr + PW'(1)] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(n_res);
      if (pop) rptr <= rptr + PW'(1);
      count <= count + (push ? CW'(n_res) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end
  end

  assign dout.valid    = (count != '0);
  assign dout.out_byte = q[rptr].out_byte;
  assign dout.part     = q[rptr].part;
  assign dout.out_last = q[rptr].out_last;
  assign dout.accepted = q[rptr].accepted;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QDEPTH))
    else $error("result queue overflow");

  a_verdict_on_last: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.accepted) |-> dout.out_last)
    else $error("accept verdict on a non-final result");

  a_slash_phase: assert property (@(posedge clk) disable iff (rst)
    slash_held |-> (phase == PH_COLON))
    else $error("held slash outside the post-colon phase");

  a_failed_ended: assert property (@(posedge clk) disable iff (rst)
    failed |-> (phase == PH_ENDED))
    else $error("failed flag set while still parsing");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push && n_res == 2'd2) |=> (count >= CW'(1)))
    else $error("two-result item left queue empty");
`endif

endmodule
